// ===== src/vln_pkg.sv =====
package vln_pkg;

  localparam int VectorLen = 25;
  localparam int PixW      = 8;
  localparam int SqW       = 2 * PixW;
  localparam int IdxW      = (VectorLen > 1) ? $clog2(VectorLen) : 1;
  localparam int SumW      = $clog2(VectorLen * 65025 + 1);
  localparam int RootW     = 17;
  localparam int XW        = 2 * RootW;
  localparam int DivSteps  = 33;
  localparam int SqrtSteps = RootW;
  localparam int StepW     = $clog2(DivSteps);
  localparam int AluW      = (SumW + 1 > 21) ? SumW + 1 : 21;

  typedef enum logic [2:0] {
    ST_FILL,
    ST_READ,
    ST_START,
    ST_CALC,
    ST_EMIT
  } vln_state_e;

  typedef enum logic [1:0] {
    EN_IDLE,
    EN_DIV,
    EN_SQRT
  } vln_eng_state_e;

  typedef struct packed {
    logic            start;
    logic [PixW-1:0] value;
    logic [SumW-1:0] sum;
  } vln_cmd_t;

  typedef struct packed {
    logic             done;
    logic [RootW-1:0] quot;
  } vln_rsp_t;

endpackage

// ===== src/vln_alu.sv =====
module vln_alu (
  input  logic [vln_pkg::AluW-1:0] a_i,
  input  logic [vln_pkg::AluW-1:0] b_i,
  output logic                     ge_o,
  output logic [vln_pkg::AluW-1:0] diff_o
);
  import vln_pkg::*;

  logic [AluW:0] sub;

  // one wide subtract, borrow gives the compare
  assign sub    = {1'b0, a_i} - {1'b0, b_i};
  assign ge_o   = ~sub[AluW];
  assign diff_o = sub[AluW-1:0];

endmodule

// ===== src/vln_engine.sv =====
module vln_engine (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  vln_pkg::vln_cmd_t cmd_i,
  output vln_pkg::vln_rsp_t rsp_o
);
  import vln_pkg::*;

  vln_eng_state_e   state_q, state_d;
  logic [StepW-1:0] step_q, step_d;
  logic [AluW-1:0]  rem_q, rem_d;
  logic [XW-1:0]    x_q, x_d;
  logic [RootW-1:0] root_q, root_d;
  logic [SumW-1:0]  sum_q, sum_d;
  logic             zero_q, zero_d;
  logic             done_q, done_d;

  logic [AluW-1:0]  alu_a, alu_b, alu_diff;
  logic             alu_ge;
  logic [SqW-1:0]   sq;

  assign sq = cmd_i.value * cmd_i.value;

  vln_alu u_alu (
    .a_i    (alu_a),
    .b_i    (alu_b),
    .ge_o   (alu_ge),
    .diff_o (alu_diff)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      EN_IDLE: if (cmd_i.start) state_d = EN_DIV;
      EN_DIV:  if (step_q == StepW'(DivSteps - 1)) state_d = EN_SQRT;
      EN_SQRT: if (step_q == StepW'(SqrtSteps - 1)) state_d = EN_IDLE;
      default: state_d = EN_IDLE;
    endcase
  end

  // operand select and datapath update
  always_comb begin
    alu_a  = '0;
    alu_b  = '0;
    step_d = step_q;
    rem_d  = rem_q;
    x_d    = x_q;
    root_d = root_q;
    sum_d  = sum_q;
    zero_d = zero_q;
    done_d = 1'b0;
    unique case (state_q)
      EN_IDLE: begin
        if (cmd_i.start) begin
          step_d = '0;
          rem_d  = {{(AluW-SqW){1'b0}}, sq};
          x_d    = '0;
          root_d = '0;
          sum_d  = cmd_i.sum;
          zero_d = (cmd_i.sum == '0);
        end
      end
      EN_DIV: begin
        // restoring division of v*v*2^32 by the sum, one quotient bit a cycle
        alu_a  = (step_q == '0) ? rem_q : {rem_q[AluW-2:0], 1'b0};
        alu_b  = {{(AluW-SumW){1'b0}}, sum_q};
        rem_d  = alu_ge ? alu_diff : alu_a;
        x_d    = {x_q[XW-2:0], alu_ge};
        step_d = step_q + 1'b1;
        if (step_q == StepW'(DivSteps - 1)) begin
          step_d = '0;
          rem_d  = '0;
        end
      end
      EN_SQRT: begin
        // digit-by-digit integer square root of the quotient
        alu_a  = {rem_q[AluW-3:0], x_q[XW-1:XW-2]};
        alu_b  = {{(AluW-RootW-2){1'b0}}, root_q, 2'b01};
        rem_d  = alu_ge ? alu_diff : alu_a;
        root_d = {root_q[RootW-2:0], alu_ge};
        x_d    = {x_q[XW-3:0], 2'b00};
        step_d = step_q + 1'b1;
        if (step_q == StepW'(SqrtSteps - 1)) begin
          step_d = '0;
          done_d = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= EN_IDLE;
      step_q  <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    x_q    <= x_d;
    root_q <= root_d;
    sum_q  <= sum_d;
    zero_q <= zero_d;
  end

  // an all-zero vector normalizes to zero
  assign rsp_o.done = done_q;
  assign rsp_o.quot = zero_q ? '0 : root_q;

endmodule

// ===== src/vector_l2_normalizer.sv =====
// after the last element of a vector is taken, each element passes in turn through store read,
// engine issue, divide, square root and output load, and the next vector is taken after the last
// result is loaded; elements are handled one at a time, since the divide and square root
// sequencer has a single shared subtract/compare unit
// reset: asynchronous active low, clears count, sum, sequencer and output valid;
// element store contents are undefined until written
module vector_l2_normalizer (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input stream
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] pixel_value
  // output stream
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o,   // [16:0] norm_value, [23:17] zero
  output logic        m_axis_tlast_o    // last_element
);
  import vln_pkg::*;

  localparam logic [IdxW-1:0] LastIdx = IdxW'(VectorLen - 1);

  vln_state_e       state_q, state_d;
  logic [IdxW-1:0]  cnt_q;            // fill position of the incoming vector
  logic [IdxW-1:0]  idx_q;            // element being normalized
  logic [SumW-1:0]  sum_q;            // running sum of squares
  logic [PixW-1:0]  rd_data_q;
  logic [PixW-1:0]  store_mem [VectorLen];

  logic             out_valid_q;
  logic [RootW-1:0] out_data_q;
  logic             out_last_q;

  logic             in_xfer;
  logic             out_free;
  logic             load_out;
  logic [SqW-1:0]   pix_sq;

  vln_cmd_t         cmd;
  vln_rsp_t         rsp;

  assign in_xfer  = s_axis_tvalid_i && s_axis_tready_o;
  // the output register can take a new result this cycle
  assign out_free = !out_valid_q || m_axis_tready_i;
  assign pix_sq   = s_axis_tdata_i * s_axis_tdata_i;

  // shared divide / square root sequencer, one result per start
  vln_engine u_engine (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .rsp_o  (rsp)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_FILL:  if (in_xfer && cnt_q == LastIdx) state_d = ST_READ;
      ST_READ:  state_d = ST_START;
      ST_START: state_d = ST_CALC;
      ST_CALC: begin
        if (rsp.done) begin
          if (!out_free)              state_d = ST_EMIT;
          else if (idx_q == LastIdx)  state_d = ST_FILL;
          else                        state_d = ST_READ;
        end
      end
      ST_EMIT: begin
        if (out_free) state_d = (idx_q == LastIdx) ? ST_FILL : ST_READ;
      end
      default: state_d = ST_FILL;
    endcase
  end

  // control outputs
  always_comb begin
    s_axis_tready_o = 1'b0;
    cmd.start       = 1'b0;
    load_out        = 1'b0;
    unique case (state_q)
      ST_FILL:  s_axis_tready_o = 1'b1;
      ST_READ:  ;
      ST_START: cmd.start = 1'b1;
      ST_CALC:  load_out = rsp.done && out_free;
      ST_EMIT:  load_out = out_free;
      default:  ;
    endcase
  end

  // stored element for the current index goes to the engine with the full sum
  assign cmd.value = rd_data_q;
  assign cmd.sum   = sum_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_FILL;
      cnt_q       <= '0;
      idx_q       <= '0;
      sum_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (in_xfer) begin
        cnt_q <= (cnt_q == LastIdx) ? '0 : cnt_q + 1'b1;
        sum_q <= sum_q + {{(SumW-SqW){1'b0}}, pix_sq};
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
        if (idx_q == LastIdx) begin
          // vector done, clear for the next one
          idx_q <= '0;
          sum_q <= '0;
        end else begin
          idx_q <= idx_q + 1'b1;
        end
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // element store, written on each input transfer, read at the normalize index
  always_ff @(posedge clk_i) begin
    if (in_xfer) store_mem[cnt_q] <= s_axis_tdata_i;
    rd_data_q <= store_mem[idx_q];
  end

  // output payload
  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_data_q <= rsp.quot;
      out_last_q <= (idx_q == LastIdx);
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{(24-RootW){1'b0}}, out_data_q};
  assign m_axis_tlast_o  = out_last_q;

  // the engine only finishes while the controller waits for it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp.done |-> state_q == ST_CALC)
    else $error("engine result outside of calc state");

  // a normalized element never exceeds one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out |-> rsp.quot <= 17'h10000)
    else $error("normalized value above one");

  // after the last element of a vector the emit index is parked at zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tlast_o) |-> idx_q == '0)
    else $error("emit index not cleared after last element");

  // input is only taken while no vector is being normalized
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready_o |-> (idx_q == '0 && !rsp.done))
    else $error("input accepted during normalization");

endmodule
